// ===== sv/srf_pkg.sv =====
// shared types and codes of the sliding window rank filter
package srf_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_WEIGHT = 2'd1;
  localparam logic [1:0] REQ_FILL   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // filter modes
  localparam logic [1:0] MODE_TMEAN  = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;
  localparam logic [1:0] MODE_WSUM   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3     = 2'd3;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned TRIM_W = 5;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [15:0] sample;
    logic        [5:0]  weight_index;
    logic signed [15:0] weight_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] filtered;
    logic               saturated;
  } out_beat_t;

endpackage

// ===== sv/srf_div.sv =====
// restoring serial divider, one quotient bit per cycle
module srf_div #(
  parameter int unsigned DVD_W = 30,
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_d;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, q_q[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    if (ge) begin
      rem_d = DVS_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[DVS_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      q_q   <= {q_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule

// ===== sv/sliding_window_rank_filter_core.sv =====
// sliding window rank filter: ring of samples with ranks, mean / median / weighted sum
//
// Input beats arrive on in_valid_i/in_ready_o. A sample beat replaces the oldest
// slot, re-ranks it and yields one result beat on out_valid_o/out_ready_i. A
// weight beat writes one rank weight; a fill beat sweeps the window. Neither
// yields a result. A sample goes through two walks over the window memories
// (counting, then rank update with accumulation, through the shared multiplier
// in weighted sum mode) and, in trimmed mean mode when the trim leaves slots,
// through the serial divider.
// in_ready_o is high only while the sequencer is idle, one item at a time.
// The result sits in an output register, so the next item can be taken while
// it waits; a later result holds the sequencer until that register is free.
// After reset a clearing pass writes zero samples, identity ranks and zero weights;
// in_ready_o stays low during it. The configuration port (cfg_valid_i/cfg_ready_o)
// is always ready; the user must write it only while idle; the block does not check.
module sliding_window_rank_filter_core #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  srf_pkg::in_beat_t                 in_beat_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output srf_pkg::out_beat_t                out_beat_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [srf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 3);
  localparam int unsigned TW    = (CNT_W > 6) ? CNT_W : 6;
  localparam int unsigned ACC_W = 32 + IDX_W;
  localparam int unsigned DVD_W = 24 + IDX_W;
  localparam int unsigned HALF  = WINDOW / 2;
  localparam bit          W_ODD = (WINDOW % 2) == 1;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_FILL  = 4'd2;
  localparam logic [3:0] ST_RDR   = 4'd3;
  localparam logic [3:0] ST_RGET  = 4'd4;
  localparam logic [3:0] ST_PASSA = 4'd5;
  localparam logic [3:0] ST_NR    = 4'd6;
  localparam logic [3:0] ST_PASSB = 4'd7;
  localparam logic [3:0] ST_EVAL  = 4'd8;
  localparam logic [3:0] ST_DIV   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // memories
  logic signed [15:0] val_mem [WINDOW];
  logic [IDX_W-1:0]   rank_mem [WINDOW];
  logic signed [15:0] w_mem [WINDOW];

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    oldest_q;
  logic [srf_pkg::MODE_W-1:0] mode_q;
  logic [srf_pkg::TRIM_W-1:0] trim_q;
  logic signed [15:0]  smp_q;
  logic [IDX_W-1:0]    r_q, nr_q;
  logic [CNT_W-1:0]    up_q, down_q;
  logic signed [ACC_W-1:0] acc_q, term_q;
  logic                v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]    i1_q;
  logic signed [15:0]  rd_val_q, x2_q, rd_w_q;
  logic [IDX_W-1:0]    rd_rank_q;
  logic                sel2_q;
  logic signed [31:0]  res_q;
  logic                sat_q, neg_q;
  logic                out_valid_q;
  srf_pkg::out_beat_t  out_q;

  logic                in_acc;
  logic [IDX_W-1:0]    cnt_idx, rd_addr, newk, w_rd_addr;
  logic                issue;
  logic signed [15:0]  x1;
  logic                sel1;
  logic [TW-1:0]       win_c, two_trim, hi_c, k_ext, trim_ext;
  logic                overtrim;
  logic [CNT_W-1:0]    nr_full;
  logic signed [31:0]  prod;
  logic signed [ACC_W-1:0] abs_acc, sh_acc;
  logic [DVD_W-1:0]    dividend, quot;
  logic                div_start, div_busy, div_done;
  logic                out_load;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cnt_idx     = cnt_q[IDX_W-1:0];
  assign issue       = ((state_q == ST_PASSA) || (state_q == ST_PASSB)) &&
                       (cnt_q < CNT_W'(WINDOW));
  assign rd_addr     = (state_q == ST_RDR) ? oldest_q : cnt_idx;

  // window bounds from trim
  always_comb begin
    win_c    = TW'(WINDOW);
    trim_ext = TW'(trim_q);
    two_trim = TW'({trim_q, 1'b0});
    overtrim = two_trim >= win_c;
    hi_c     = win_c - trim_ext;
  end

  // new rank after insertion
  assign nr_full = CNT_W'(r_q) + up_q - down_q;

  // rank update and term selection for the second walk
  always_comb begin
    newk = rd_rank_q;
    x1   = rd_val_q;
    if (i1_q == oldest_q) begin
      newk = nr_q;
      x1   = smp_q;
    end else if ((nr_q > r_q) && (rd_rank_q > r_q) && (rd_rank_q <= nr_q)) begin
      newk = rd_rank_q - 1'b1;
    end else if ((nr_q < r_q) && (rd_rank_q >= nr_q) && (rd_rank_q < r_q)) begin
      newk = rd_rank_q + 1'b1;
    end
    k_ext = TW'(newk);
    case (mode_q)
      srf_pkg::MODE_TMEAN, srf_pkg::MODE_WSUM: begin
        sel1 = (k_ext >= trim_ext) && (k_ext < hi_c);
      end
      srf_pkg::MODE_MEDIAN: begin
        sel1 = (k_ext == TW'(HALF)) || (!W_ODD && (k_ext == TW'(HALF - 1)));
      end
      default: begin
        sel1 = 1'b0;
      end
    endcase
    w_rd_addr = newk;
  end

  // sample and rank memories
  always_ff @(posedge clk_i) begin
    rd_val_q  <= val_mem[rd_addr];
    rd_rank_q <= rank_mem[rd_addr];
    if ((state_q == ST_CLR) || (state_q == ST_FILL)) begin
      val_mem[cnt_idx]  <= (state_q == ST_CLR) ? 16'sd0 : smp_q;
      rank_mem[cnt_idx] <= cnt_idx;
    end else if (state_q == ST_PASSB && v1_q) begin
      rank_mem[i1_q] <= newk;
      if (i1_q == oldest_q) begin
        val_mem[i1_q] <= smp_q;
      end
    end
  end

  // weight memory
  always_ff @(posedge clk_i) begin
    rd_w_q <= w_mem[w_rd_addr];
    if (state_q == ST_CLR) begin
      w_mem[cnt_idx] <= 16'sd0;
    end else if (in_acc && (in_beat_i.req_type == srf_pkg::REQ_WEIGHT) &&
                 (TW'(in_beat_i.weight_index) < win_c)) begin
      w_mem[IDX_W'(in_beat_i.weight_index)] <= in_beat_i.weight_value;
    end
  end

  // shared multiplier stage
  assign prod = rd_w_q * x2_q;

  // walk pipeline and datapath registers
  always_ff @(posedge clk_i) begin
    i1_q   <= cnt_idx;
    x2_q   <= x1;
    sel2_q <= sel1;
    if (mode_q == srf_pkg::MODE_WSUM) begin
      term_q <= sel2_q ? ACC_W'(prod) : '0;
    end else begin
      term_q <= sel2_q ? ACC_W'(x2_q) : '0;
    end
    if (in_acc) begin
      smp_q <= in_beat_i.sample;
    end
    if (state_q == ST_RGET) begin
      r_q <= rd_rank_q;
    end
    if (state_q == ST_NR) begin
      nr_q <= nr_full[IDX_W-1:0];
    end
  end

  // valid flags of the walk pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q && (state_q == ST_PASSB);
      v3_q <= v2_q;
    end
  end

  // counting walk and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= '0;
      down_q <= '0;
      acc_q  <= '0;
    end else if (state_q == ST_RGET) begin
      up_q   <= '0;
      down_q <= '0;
      acc_q  <= '0;
    end else begin
      if (state_q == ST_PASSA && v1_q && (i1_q != oldest_q)) begin
        if ((rd_rank_q > r_q) && (rd_val_q < smp_q)) begin
          up_q <= up_q + 1'b1;
        end
        if ((rd_rank_q < r_q) && (rd_val_q > smp_q)) begin
          down_q <= down_q + 1'b1;
        end
      end
      if (v3_q) begin
        acc_q <= acc_q + term_q;
      end
    end
  end

  // result forming
  always_comb begin
    abs_acc  = acc_q[ACC_W-1] ? -acc_q : acc_q;
    dividend = {abs_acc[DVD_W-9:0], 8'd0};
    sh_acc   = acc_q >>> 6;
  end

  assign div_start = (state_q == ST_EVAL) && (mode_q == srf_pkg::MODE_TMEAN) && !overtrim;

  srf_div #(
    .DVD_W(DVD_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (CNT_W'(win_c - two_trim)),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      neg_q <= acc_q[ACC_W-1];
      res_q <= '0;
      sat_q <= 1'b0;
      case (mode_q)
        srf_pkg::MODE_MEDIAN: begin
          res_q <= W_ODD ? 32'(acc_q <<< 8) : 32'(acc_q <<< 7);
        end
        srf_pkg::MODE_WSUM: begin
          if (!overtrim) begin
            if (sh_acc > ACC_W'(32'sh7fffffff)) begin
              res_q <= 32'sh7fffffff;
              sat_q <= 1'b1;
            end else if (sh_acc < -ACC_W'(33'sh80000000)) begin
              res_q <= 32'sh80000000;
              sat_q <= 1'b1;
            end else begin
              res_q <= 32'(sh_acc);
            end
          end
        end
        default: begin
          res_q <= '0;
        end
      endcase
    end else if (state_q == ST_DIV && div_done) begin
      res_q <= neg_q ? -32'(quot) : 32'(quot);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR: begin
        if (cnt_q == CNT_W'(WINDOW - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_beat_i.req_type)
            srf_pkg::REQ_SAMPLE: state_d = ST_RDR;
            srf_pkg::REQ_FILL:   state_d = ST_FILL;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (cnt_q == CNT_W'(WINDOW - 1)) state_d = ST_IDLE;
      end
      ST_RDR:   state_d = ST_RGET;
      ST_RGET:  state_d = ST_PASSA;
      ST_PASSA: begin
        if (cnt_q == CNT_W'(WINDOW)) state_d = ST_NR;
      end
      ST_NR:    state_d = ST_PASSB;
      ST_PASSB: begin
        if (cnt_q == CNT_W'(WINDOW + 2)) state_d = ST_EVAL;
      end
      ST_EVAL:  state_d = div_start ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      cnt_q    <= '0;
      oldest_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_FILL) begin
        oldest_q <= '0;
      end else if (state_q == ST_PASSB && state_d == ST_EVAL) begin
        oldest_q <= (oldest_q == IDX_W'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= srf_pkg::MODE_MEDIAN;
      trim_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        srf_pkg::CFG_FILTER_MODE: mode_q <= cfg_data_i[srf_pkg::MODE_W-1:0];
        srf_pkg::CFG_TRIM_COUNT:  trim_q <= cfg_data_i[srf_pkg::TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.filtered  <= res_q;
      out_q.saturated <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // new rank stays inside the window
  a_nr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NR) |-> (nr_full < CNT_W'(WINDOW)))
    else $error("new rank out of window");

  // counts cover at most the other slots
  a_cnt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NR) |-> ((up_q + down_q) < CNT_W'(WINDOW)))
    else $error("rank move counts too large");

  // divider runs only under the divide step
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide step");

  // finished result waits while the output register is held
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result dropped while output stalled");

endmodule
